// File: hdl/vsvm_pkg.sv
// ----------------------------------------------------------------------------
// vsvm_pkg: shared types and constants of the surface voxel marker
// Item payloads, configuration register indexes, reset values and the
// size clamping helper used by the marker.
// ----------------------------------------------------------------------------
package vsvm_pkg;

   localparam int LABEL_W   = 12;
   localparam int Z_W       = 13;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 3;
   localparam int Z_MAX     = 1 << Z_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INSIDE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT      = 3'd6;

   localparam logic [Z_W-1:0]     SIZE_RESET     = 13'd256;
   localparam logic [LABEL_W-1:0] INSIDE_RESET   = 12'd2000;
   localparam logic [LABEL_W-1:0] BOUNDARY_RESET = 12'd3000;
   localparam logic [LABEL_W-1:0] CUT_RESET      = 12'd1000;

   typedef struct packed {
      logic [LABEL_W-1:0] voxel_value;
      logic               implant_inside;
      logic               flush;
   } vsvm_req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label_out;
      logic               is_last;
   } vsvm_rsp_type;

   typedef struct packed {
      logic               mode;
      logic [LABEL_W-1:0] inside_label;
      logic [LABEL_W-1:0] boundary_label;
      logic [LABEL_W-1:0] cut_label;
   } vsvm_cfg_type;

   // Center voxel and five face neighbours, all but above, from the plane store.
   typedef struct packed {
      logic [LABEL_W-1:0] center;
      logic [LABEL_W-1:0] left;
      logic [LABEL_W-1:0] right;
      logic [LABEL_W-1:0] up;
      logic [LABEL_W-1:0] down;
      logic [LABEL_W-1:0] below;
   } vsvm_nbr_type;

   // Per-result control that travels alongside the store read.
   typedef struct packed {
      logic [LABEL_W-1:0] above;
      logic               left_ok;
      logic               right_ok;
      logic               up_ok;
      logic               down_ok;
      logic               below_ok;
      logic               above_ok;
      logic               face;
      logic               is_last;
   } vsvm_flags_type;

   // Last valid index for a size register: zero acts as one, and the size
   // saturates at max_cnt.
   function automatic logic [Z_W-1:0] last_index(input logic [Z_W-1:0] raw,
                                                 input int unsigned max_cnt);
      logic [Z_W-1:0] res;
      if (raw == '0) begin
         res = '0;
      end else if (32'(raw) > max_cnt) begin
         res = Z_W'(max_cnt - 1);
      end else begin
         res = raw - 1'b1;
      end
      return res;
   endfunction

endpackage

// File: hdl/vsvm_stream_if.sv
// ----------------------------------------------------------------------------
// vsvm_stream_if: valid/ready item channel
// Carries one payload per item; an item moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface vsvm_stream_if #(parameter type data_type = logic) ();

   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

// File: hdl/vsvm_raster_cnt.sv
// ----------------------------------------------------------------------------
// vsvm_raster_cnt: x, y, z position counter in raster order
// Steps x fastest, then y, then z, and flags the last position of the volume.
// ----------------------------------------------------------------------------
module vsvm_raster_cnt #(
   parameter int XW = 8,
   parameter int YW = 8,
   parameter int ZW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          step,
   input  logic [XW-1:0] x_last,
   input  logic [YW-1:0] y_last,
   input  logic [ZW-1:0] z_last,
   output logic [XW-1:0] x,
   output logic [YW-1:0] y,
   output logic [ZW-1:0] z,
   output logic          wrap
);

   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [ZW-1:0] z_ff, z_in;
   logic          x_end, y_end, z_end;

   assign x_end = (x_ff == x_last);
   assign y_end = (y_ff == y_last);
   assign z_end = (z_ff == z_last);
   assign wrap  = x_end && y_end && z_end;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      priority if (clear) begin
         x_in = '0;
         y_in = '0;
         z_in = '0;
      end else if (step) begin
         if (x_end) begin
            x_in = '0;
            if (y_end) begin
               y_in = '0;
               if (z_end) begin
                  z_in = '0;
               end else begin
                  z_in = z_ff + 1'b1;
               end
            end else begin
               y_in = y_ff + 1'b1;
            end
         end else begin
            x_in = x_ff + 1'b1;
         end
      end else begin
         x_in = x_ff;
         y_in = y_ff;
         z_in = z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         z_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;

endmodule

// File: hdl/vsvm_plane_store.sv
// ----------------------------------------------------------------------------
// vsvm_plane_store: two-plane voxel store with six registered reads
// Three copies of the store take the same write; each copy serves two reads,
// so the center voxel and five face neighbours come out in the same cycle.
// ----------------------------------------------------------------------------
module vsvm_plane_store #(
   parameter int AW = 17
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [AW-1:0]              waddr,
   input  logic [vsvm_pkg::LABEL_W-1:0] wdata,
   input  logic                       re,
   input  logic [AW-1:0]              addr_center,
   input  logic [AW-1:0]              addr_left,
   input  logic [AW-1:0]              addr_right,
   input  logic [AW-1:0]              addr_up,
   input  logic [AW-1:0]              addr_down,
   input  logic [AW-1:0]              addr_below,
   output vsvm_pkg::vsvm_nbr_type     nbr
);

   import vsvm_pkg::*;

   localparam int DEPTH = 1 << AW;

   logic [LABEL_W-1:0] copy_a_ff [DEPTH];
   logic [LABEL_W-1:0] copy_b_ff [DEPTH];
   logic [LABEL_W-1:0] copy_c_ff [DEPTH];
   vsvm_nbr_type       nbr_ff;

   // The below read can hit the address written in the same cycle; it must
   // return the older plane, which read-before-write gives.
   always_ff @(posedge clock) begin
      if (we) begin
         copy_a_ff[waddr] <= wdata;
         copy_b_ff[waddr] <= wdata;
         copy_c_ff[waddr] <= wdata;
      end
      if (re) begin
         nbr_ff.center <= copy_a_ff[addr_center];
         nbr_ff.left   <= copy_a_ff[addr_left];
         nbr_ff.right  <= copy_b_ff[addr_right];
         nbr_ff.up     <= copy_b_ff[addr_up];
         nbr_ff.down   <= copy_c_ff[addr_down];
         nbr_ff.below  <= copy_c_ff[addr_below];
      end
   end

   assign nbr = nbr_ff;

endmodule

// File: hdl/vsvm_decide.sv
// ----------------------------------------------------------------------------
// vsvm_decide: boundary decision and result register
// Compares the neighbours with the trigger label and holds the result item
// until the sink takes it.
// ----------------------------------------------------------------------------
module vsvm_decide (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  vsvm_pkg::vsvm_flags_type flags,
   input  vsvm_pkg::vsvm_nbr_type   nbr,
   input  vsvm_pkg::vsvm_cfg_type   cfg,
   output logic                     free,
   vsvm_stream_if.source            rsp_if
);

   import vsvm_pkg::*;

   logic               p_valid_ff, p_valid_in;
   vsvm_flags_type     p_flags_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   vsvm_rsp_type       rsp_data_ff, rsp_data_in;
   logic               move;
   logic               hit;
   logic [LABEL_W-1:0] trig;

   assign move = p_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign free = !p_valid_ff || move;

   always_comb begin
      trig = cfg.mode ? cfg.cut_label : '0;
      hit  = (p_flags_ff.left_ok  && (nbr.left  == trig)) ||
             (p_flags_ff.right_ok && (nbr.right == trig)) ||
             (p_flags_ff.up_ok    && (nbr.up    == trig)) ||
             (p_flags_ff.down_ok  && (nbr.down  == trig)) ||
             (p_flags_ff.below_ok && (nbr.below == trig)) ||
             (p_flags_ff.above_ok && (p_flags_ff.above == trig)) ||
             p_flags_ff.face;
      rsp_data_in.is_last   = p_flags_ff.is_last;
      rsp_data_in.label_out = (nbr.center == cfg.inside_label && hit) ?
                              cfg.boundary_label : nbr.center;
   end

   always_comb begin
      p_valid_in   = load ? 1'b1 : (move ? 1'b0 : p_valid_ff);
      rsp_valid_in = move ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p_flags_ff <= flags;
      end
      if (move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

// File: hdl/volume_surface_voxel_marker.sv
// ----------------------------------------------------------------------------
// volume_surface_voxel_marker: six-neighbour boundary voxel marker
// Voxels stream in raster order, one per item, at one item per clock cycle
// while the result sink keeps taking results. Each voxel is remapped (cut
// mode), written to a two-plane store, and the voxel one plane behind is
// decided from its six face neighbours, so results lag the input by one
// plane; flush items drain the last plane and the final result carries
// is_last. Each result passes the registered store read and then the
// decision into the result register. The store holds two planes of
// 2^ceil(log2(MAX_HEIGHT)) rows by 2^ceil(log2(MAX_WIDTH)) voxels in three
// copies with two read ports each; it needs no clearing after reset.
// Writing a size register restarts the volume.
// ----------------------------------------------------------------------------
module volume_surface_voxel_marker #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   vsvm_stream_if.sink                    req_if,
   vsvm_stream_if.source                  rsp_if,
   input  logic                           csr_we,
   input  logic [vsvm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vsvm_pkg::CSR_W-1:0]     csr_wdata
);

   import vsvm_pkg::*;

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW = 1 + YW + XW;

   // Configuration registers; sizes are kept as last indexes.
   logic               mode_ff;
   logic [XW-1:0]      x_last_ff;
   logic [YW-1:0]      y_last_ff;
   logic [Z_W-1:0]     z_last_ff;
   logic [LABEL_W-1:0] inside_ff, boundary_ff, cut_ff;

   logic               drain_pending_ff, drain_pending_in;
   logic               acc, is_voxel, is_drain, emit, restart, size_write;
   logic [LABEL_W-1:0] remapped;
   logic               free;

   logic [XW-1:0]      in_x, out_x;
   logic [YW-1:0]      in_y, out_y;
   logic [Z_W-1:0]     in_z, out_z;
   logic               in_wrap, out_wrap;

   vsvm_flags_type     flags;
   vsvm_nbr_type       nbr;
   vsvm_cfg_type       cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         x_last_ff   <= XW'(last_index(SIZE_RESET, MAX_WIDTH));
         y_last_ff   <= YW'(last_index(SIZE_RESET, MAX_HEIGHT));
         z_last_ff   <= last_index(SIZE_RESET, Z_MAX);
         inside_ff   <= INSIDE_RESET;
         boundary_ff <= BOUNDARY_RESET;
         cut_ff      <= CUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:     mode_ff     <= csr_wdata[0];
            CSR_SIZE_X:   x_last_ff   <= XW'(last_index(Z_W'(csr_wdata[8:0]), MAX_WIDTH));
            CSR_SIZE_Y:   y_last_ff   <= YW'(last_index(Z_W'(csr_wdata[8:0]), MAX_HEIGHT));
            CSR_SIZE_Z:   z_last_ff   <= last_index(csr_wdata, Z_MAX);
            CSR_INSIDE:   inside_ff   <= csr_wdata[LABEL_W-1:0];
            CSR_BOUNDARY: boundary_ff <= csr_wdata[LABEL_W-1:0];
            CSR_CUT:      cut_ff      <= csr_wdata[LABEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.mode           = mode_ff;
   assign cfg.inside_label   = inside_ff;
   assign cfg.boundary_label = boundary_ff;
   assign cfg.cut_label      = cut_ff;

   assign req_if.ready = free;
   assign acc          = req_if.valid && req_if.ready;
   // A voxel while a drain is pending, or a flush without one, is dropped.
   assign is_voxel     = acc && !req_if.data.flush && !drain_pending_ff;
   assign is_drain     = acc && req_if.data.flush && drain_pending_ff;
   assign emit         = (is_voxel && (in_z != '0)) || is_drain;
   assign size_write   = csr_we && ((csr_index == CSR_SIZE_X) ||
                                    (csr_index == CSR_SIZE_Y) ||
                                    (csr_index == CSR_SIZE_Z));
   assign restart      = size_write || (is_drain && out_wrap);

   assign remapped = (mode_ff && (req_if.data.voxel_value != '0) &&
                      req_if.data.implant_inside) ? cut_ff : req_if.data.voxel_value;

   always_comb begin
      priority if (restart) begin
         drain_pending_in = 1'b0;
      end else if (is_voxel && in_wrap) begin
         drain_pending_in = 1'b1;
      end else begin
         drain_pending_in = drain_pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_pending_ff <= 1'b0;
      end else begin
         drain_pending_ff <= drain_pending_in;
      end
   end

   vsvm_raster_cnt #(.XW(XW), .YW(YW), .ZW(Z_W)) u_in_cnt (
      .clock  (clock),
      .reset  (reset),
      .clear  (restart),
      .step   (is_voxel),
      .x_last (x_last_ff),
      .y_last (y_last_ff),
      .z_last (z_last_ff),
      .x      (in_x),
      .y      (in_y),
      .z      (in_z),
      .wrap   (in_wrap)
   );

   vsvm_raster_cnt #(.XW(XW), .YW(YW), .ZW(Z_W)) u_out_cnt (
      .clock  (clock),
      .reset  (reset),
      .clear  (restart),
      .step   (emit),
      .x_last (x_last_ff),
      .y_last (y_last_ff),
      .z_last (z_last_ff),
      .x      (out_x),
      .y      (out_y),
      .z      (out_z),
      .wrap   (out_wrap)
   );

   always_comb begin
      flags.above    = remapped;
      flags.left_ok  = (out_x != '0);
      flags.right_ok = (out_x != x_last_ff);
      flags.up_ok    = (out_y != '0);
      flags.down_ok  = (out_y != y_last_ff);
      flags.below_ok = (out_z != '0);
      flags.above_ok = !req_if.data.flush;
      // Surface mode also marks inside voxels on any face of the volume.
      flags.face     = !mode_ff && ((out_x == '0) || (out_x == x_last_ff) ||
                                    (out_y == '0) || (out_y == y_last_ff) ||
                                    (out_z == '0) || (out_z == z_last_ff));
      flags.is_last  = is_drain && out_wrap;
   end

   vsvm_plane_store #(.AW(AW)) u_store (
      .clock       (clock),
      .we          (is_voxel),
      .waddr       ({in_z[0], in_y, in_x}),
      .wdata       (remapped),
      .re          (emit),
      .addr_center ({out_z[0], out_y, out_x}),
      .addr_left   ({out_z[0], out_y, XW'(out_x - 1'b1)}),
      .addr_right  ({out_z[0], out_y, XW'(out_x + 1'b1)}),
      .addr_up     ({out_z[0], YW'(out_y - 1'b1), out_x}),
      .addr_down   ({out_z[0], YW'(out_y + 1'b1), out_x}),
      .addr_below  ({~out_z[0], out_y, out_x}),
      .nbr         (nbr)
   );

   vsvm_decide u_decide (
      .clock  (clock),
      .reset  (reset),
      .load   (emit),
      .flags  (flags),
      .nbr    (nbr),
      .cfg    (cfg),
      .free   (free),
      .rsp_if (rsp_if)
   );

   a_drain_at_origin: assert property (@(posedge clock) disable iff (reset)
      drain_pending_ff |-> (in_x == '0 && in_y == '0 && in_z == '0))
      else $error("input position left the origin while a drain is pending");

   a_out_lags_in: assert property (@(posedge clock) disable iff (reset)
      (!drain_pending_ff && in_z != '0) |->
         (out_x == in_x && out_y == in_y && out_z == in_z - 1'b1))
      else $error("output position is not one plane behind the input position");

   a_out_first_plane: assert property (@(posedge clock) disable iff (reset)
      (!drain_pending_ff && in_z == '0) |->
         (out_x == '0 && out_y == '0 && out_z == '0))
      else $error("output position moved during the first plane");

endmodule
